### rtl/core/dts_pkg.sv
`default_nettype none

package dts_pkg;

  // Field widths
  localparam int unsigned NODE_W  = 5;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned OP_W    = 1;

  // A dependency row holds one bit per possible required_node
  localparam int unsigned ROW_W       = 1 << NODE_W;
  localparam int unsigned NODE_LIMIT  = 1 << NODE_W;

  localparam int unsigned MAX_NODES_DEF = 32;
  localparam logic [CNT_W-1:0] NUM_NODES_RST = CNT_W'(1);

  typedef enum logic [OP_W-1:0] {
    OP_ADD_EDGE = 1'b0,
    OP_START    = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CYCLE
  } state_e;

endpackage

`default_nettype wire

### rtl/core/dependency_topological_sort_top.sv
`default_nettype none

// Edge transaction: accepted while idle, no result.
// Start transaction: one row check per cycle unless the output stalls, up to n passes over
// n nodes (n = node count, limited to MAX_NODES and 32); ST_CYCLE loads a cycle result.
// The node checks share one row-vs-visited compare; in_stall_o is high for the whole run.
// Each result sits in an output register; the next transaction is taken once the run ends.
// Reset: node total 1, dependency matrix empty (per-row valid bits cleared), output empty.
module dependency_topological_sort_top #(
  parameter int unsigned MAX_NODES = dts_pkg::MAX_NODES_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [dts_pkg::CNT_W-1:0]    cfg_wdata_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [dts_pkg::OP_W-1:0]     op_i,
  input  wire logic [dts_pkg::NODE_W-1:0]   dependent_node_i,
  input  wire logic [dts_pkg::NODE_W-1:0]   required_node_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [dts_pkg::NODE_W-1:0]        ordered_node_o,
  output logic                              cycle_found_o,
  output logic                              last_o
);
  import dts_pkg::*;

  localparam int unsigned ROWS = (MAX_NODES < NODE_LIMIT) ? MAX_NODES : NODE_LIMIT;
  localparam int unsigned IW   = $clog2(ROWS);
  localparam int unsigned NW   = $clog2(ROWS + 1);

  state_e state_q, state_d;

  logic [CNT_W-1:0]  num_nodes_q;
  logic [NW-1:0]     n_q, n_d;
  logic [NW-1:0]     placed_q, placed_d, placed_inc;
  logic [IW-1:0]     idx_q, idx_d;
  logic              prog_q, prog_d;
  logic [ROWS-1:0]   visited_q, visited_d;
  logic [ROWS-1:0]   row_vld_q;
  logic [ROW_W-1:0]  rows_q [ROWS];

  logic              out_valid_q;
  logic [NODE_W-1:0] out_node_q;
  logic              out_cyc_q;
  logic              out_last_q;

  logic              in_acc;
  logic              edge_acc;
  logic              start_acc;
  logic              edge_ok;
  logic [IW-1:0]     edge_idx;
  logic [NW-1:0]     n_start;

  logic [ROW_W-1:0]  row_rd_q;
  logic [ROW_W-1:0]  vis_ext;
  logic              blocked;
  logic              candidate;
  logic              slot_free;
  logic              place;
  logic              advance;
  logic              last_node;
  logic              run_done;
  logic              load_cyc;

  // ---------------------------------------------------------------------------
  // Handshake and decode
  // ---------------------------------------------------------------------------
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign edge_acc   = in_acc && (op_e'(op_i) == OP_ADD_EDGE);
  assign start_acc  = in_acc && (op_e'(op_i) == OP_START);
  assign edge_ok    = (CNT_W'(dependent_node_i) < CNT_W'(ROWS));
  assign edge_idx   = IW'(dependent_node_i);

  assign n_start = (num_nodes_q > CNT_W'(ROWS)) ? NW'(ROWS) : NW'(num_nodes_q);

  assign slot_free = !out_valid_q || !out_stall_i;

  // Shared row check: a node is ready when all its dependencies are visited
  assign vis_ext    = ROW_W'(visited_q);
  assign blocked    = |(row_rd_q & ~vis_ext);
  assign candidate  = !visited_q[idx_q] && !blocked;
  assign last_node  = (idx_q == IW'(n_q - 1'b1));
  assign placed_inc = NW'(placed_q + 1'b1);

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_acc) begin
          state_d = (n_start == '0) ? ST_CYCLE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!candidate || slot_free) begin
          if (candidate && (placed_inc == n_q)) begin
            state_d = ST_IDLE;
          end else if (last_node && !(prog_q || candidate)) begin
            state_d = ST_CYCLE;
          end
        end
      end
      ST_CYCLE: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    place     = 1'b0;
    advance   = 1'b0;
    load_cyc  = 1'b0;
    n_d       = n_q;
    idx_d     = idx_q;
    prog_d    = prog_q;
    visited_d = visited_q;
    placed_d  = placed_q;
    case (state_q)
      ST_IDLE: begin
        if (start_acc) begin
          n_d       = n_start;
          idx_d     = '0;
          prog_d    = 1'b0;
          visited_d = '0;
          placed_d  = '0;
        end
      end
      ST_SCAN: begin
        place   = candidate && slot_free;
        advance = !candidate || slot_free;
        if (advance) begin
          idx_d  = last_node ? '0 : IW'(idx_q + 1'b1);
          prog_d = last_node ? 1'b0 : (prog_q || place);
        end
        if (place) begin
          visited_d[idx_q] = 1'b1;
          placed_d         = placed_inc;
        end
      end
      ST_CYCLE: begin
        load_cyc = slot_free;
      end
      default: ;
    endcase
  end

  assign run_done = (state_q != ST_IDLE) && (state_d == ST_IDLE);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      num_nodes_q  <= NUM_NODES_RST;
      n_q          <= '0;
      idx_q        <= '0;
      prog_q       <= 1'b0;
      visited_q    <= '0;
      placed_q     <= '0;
      row_vld_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      idx_q   <= idx_d;
      prog_q  <= prog_d;
      if (cfg_we_i) begin
        num_nodes_q <= cfg_wdata_i;
      end
      if (run_done) begin
        visited_q <= '0;
        placed_q  <= '0;
        row_vld_q <= '0;
      end else begin
        visited_q <= visited_d;
        placed_q  <= placed_d;
        if (edge_acc && edge_ok) begin
          row_vld_q[edge_idx] <= 1'b1;
        end
      end
      if (place || load_cyc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Dependency rows; a row that is not valid reads as zero.
  // The read follows idx_d so row_rd_q holds the row of idx_q.
  always_ff @(posedge clk_i) begin
    if (edge_acc && edge_ok) begin
      if (!row_vld_q[edge_idx]) begin
        rows_q[edge_idx] <= ROW_W'(1) << required_node_i;
      end else begin
        rows_q[edge_idx][required_node_i] <= 1'b1;
      end
    end
    row_rd_q <= row_vld_q[idx_d] ? rows_q[idx_d] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (place) begin
      out_node_q <= NODE_W'(idx_q);
      out_cyc_q  <= 1'b0;
      out_last_q <= (placed_inc == n_q);
    end else if (load_cyc) begin
      out_node_q <= '0;
      out_cyc_q  <= 1'b1;
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign ordered_node_o = out_node_q;
  assign cycle_found_o  = out_cyc_q;
  assign last_o         = out_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_placed_below_n: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (placed_q < n_q))
    else $error("placed count reached node count while scanning");

  a_visited_matches_placed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'($countones(visited_q)) == 32'(placed_q)))
    else $error("visited mask and placed count disagree");

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (32'(idx_q) < 32'(n_q)))
    else $error("scan index beyond node count");

  a_matrix_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_done |=> (row_vld_q == '0) && (visited_q == '0))
    else $error("dependency matrix not cleared after run");

  a_no_load_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !(place || load_cyc))
    else $error("result loaded over a held result");

endmodule

`default_nettype wire
